// ----- rtl/sdtq_pkg.sv -----
// Package for the sorted deadline timer queue: default sizes, function codes,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package sdtq_pkg;

  localparam int DEF_NUM_TIMERS = 16;
  localparam int DEF_TIME_BITS  = 32;

  // Most expirations reported by one service item
  localparam int MAX_BURST    = 16;
  localparam int BURST_BITS   = $clog2(MAX_BURST + 1);

  localparam logic [1:0] FUNC_ARM     = 2'd0;
  localparam logic [1:0] FUNC_STOP    = 2'd1;
  localparam logic [1:0] FUNC_SERVICE = 2'd2;

  typedef enum logic [1:0] {
    EMIT_CMD,
    EMIT_FIRE,
    EMIT_NONE
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       unlink;
    logic       link;
    logic       pop;
    logic       emit;
    emit_kind_t emit_kind;
    logic       emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       slot_ok;
    logic       head_due;
    logic       out_free;
  } dp_status_t;

endpackage

// ----- rtl/sdtq_dp.sv -----
// Datapath of the timer queue: sorted entry list, armed flags, item registers
// and the result register. Depends on sdtq_pkg; driven by sdtq_ctrl.
module sdtq_dp #(
  parameter int NUM_TIMERS = sdtq_pkg::DEF_NUM_TIMERS,
  parameter int TIME_BITS  = sdtq_pkg::DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdtq_pkg::dp_cmd_t   cmd,
  output sdtq_pkg::dp_status_t st,
  input  logic [1:0]          in_func,
  input  logic [3:0]          in_slot,
  input  logic [30:0]         in_delay,
  input  logic [31:0]         in_now,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_expired_slot,
  output logic                out_fired,
  output logic                out_slot_active,
  output logic                out_last
);

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  // True when (a - b) read as a signed value is above zero
  function automatic logic later_than(input logic [TIME_BITS-1:0] a,
                                      input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  logic [1:0]           func_r;
  logic [3:0]           slot_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] new_dl_r;
  logic [SW-1:0]        pend_r;

  logic [SW-1:0]        slot_q_r   [NUM_TIMERS];
  logic [SW-1:0]        slot_q_nxt [NUM_TIMERS];
  logic [TIME_BITS-1:0] dl_q_r     [NUM_TIMERS];
  logic [TIME_BITS-1:0] dl_q_nxt   [NUM_TIMERS];
  logic [CW-1:0]        count_r;
  logic [NUM_TIMERS-1:0] armed_r;

  logic                 out_valid_r;
  logic [3:0]           out_slot_r;
  logic                 out_fired_r;
  logic                 out_active_r;
  logic                 out_last_r;

  logic [SW-1:0]         slot_idx;
  logic                  slot_ok;
  logic                  full;
  logic                  out_free;
  logic                  active_now;
  logic [NUM_TIMERS-1:0] valid_v;
  logic [NUM_TIMERS-1:0] match_v;
  logic [NUM_TIMERS-1:0] keep_v;
  logic [NUM_TIMERS-1:0] above_v;
  logic [NUM_TIMERS-1:0] ins_v;
  logic [NUM_TIMERS-1:0] up_v;

  assign slot_idx   = SW'(slot_r);
  assign slot_ok    = int'(slot_r) < NUM_TIMERS;
  assign full       = count_r == CW'(NUM_TIMERS);
  assign out_free   = !out_valid_r || out_ready;
  assign active_now = slot_ok && (func_r inside {sdtq_pkg::FUNC_ARM, sdtq_pkg::FUNC_STOP})
                      && armed_r[slot_idx];

  assign st.func     = func_r;
  assign st.slot_ok  = slot_ok;
  assign st.head_due = (count_r != '0) && !later_than(dl_q_r[0], now_r);
  assign st.out_free = out_free;

  // Per-entry compare and shift network
  for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_entry
    logic [SW-1:0]        upper_slot;
    logic [TIME_BITS-1:0] upper_dl;
    logic [SW-1:0]        lower_slot;
    logic [TIME_BITS-1:0] lower_dl;

    assign valid_v[j] = CW'(j) < count_r;
    assign match_v[j] = valid_v[j] && (slot_q_r[j] == slot_idx);
    // Entry sits at or above the matched entry
    assign above_v[j] = |(match_v & ~({NUM_TIMERS{1'b1}} << (j + 1)));

    if (j < NUM_TIMERS - 1) begin : g_up
      assign upper_slot = slot_q_r[j+1];
      assign upper_dl   = dl_q_r[j+1];
    end else begin : g_top
      assign upper_slot = slot_q_r[j];
      assign upper_dl   = dl_q_r[j];
    end

    if (j > 0) begin : g_lo
      assign lower_slot = slot_q_r[j-1];
      assign lower_dl   = dl_q_r[j-1];
      // Keep only the leading run of entries that are not later than the new one
      assign keep_v[j]  = valid_v[j] && !later_than(dl_q_r[j], new_dl_r) && keep_v[j-1];
      assign ins_v[j]   = !keep_v[j] && keep_v[j-1];
      assign up_v[j]    = valid_v[j-1] && !keep_v[j-1];
    end else begin : g_bot
      assign lower_slot = slot_q_r[j];
      assign lower_dl   = dl_q_r[j];
      assign keep_v[j]  = valid_v[j] && !later_than(dl_q_r[j], new_dl_r);
      assign ins_v[j]   = !keep_v[j];
      assign up_v[j]    = 1'b0;
    end

    always_comb begin
      slot_q_nxt[j] = slot_q_r[j];
      dl_q_nxt[j]   = dl_q_r[j];
      if (cmd.pop || (cmd.unlink && above_v[j])) begin
        slot_q_nxt[j] = upper_slot;
        dl_q_nxt[j]   = upper_dl;
      end else if (cmd.link && !full) begin
        if (ins_v[j]) begin
          slot_q_nxt[j] = slot_idx;
          dl_q_nxt[j]   = new_dl_r;
        end else if (up_v[j]) begin
          slot_q_nxt[j] = lower_slot;
          dl_q_nxt[j]   = lower_dl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      slot_r   <= in_slot;
      now_r    <= TIME_BITS'(in_now);
      new_dl_r <= TIME_BITS'(in_now) + TIME_BITS'(in_delay);
    end
    if (cmd.pop) begin
      pend_r <= slot_q_r[0];
    end
    for (int j = 0; j < NUM_TIMERS; j++) begin
      slot_q_r[j] <= slot_q_nxt[j];
      dl_q_r[j]   <= dl_q_nxt[j];
    end
    if (cmd.emit) begin
      case (cmd.emit_kind)
        sdtq_pkg::EMIT_CMD: begin
          out_slot_r   <= 4'd0;
          out_fired_r  <= 1'b0;
          out_active_r <= active_now;
          out_last_r   <= 1'b1;
        end
        sdtq_pkg::EMIT_FIRE: begin
          out_slot_r   <= 4'(pend_r);
          out_fired_r  <= 1'b1;
          out_active_r <= 1'b0;
          out_last_r   <= cmd.emit_last;
        end
        default: begin
          out_slot_r   <= 4'd0;
          out_fired_r  <= 1'b0;
          out_active_r <= 1'b0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pop) begin
        count_r                <= count_r - 1'b1;
        armed_r[slot_q_r[0]]   <= 1'b0;
      end else if (cmd.unlink) begin
        if (|match_v) begin
          count_r <= count_r - 1'b1;
        end
        armed_r[slot_idx] <= 1'b0;
      end else if (cmd.link && !full) begin
        count_r           <= count_r + 1'b1;
        armed_r[slot_idx] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = out_slot_r;
  assign out_fired        = out_fired_r;
  assign out_slot_active  = out_active_r;
  assign out_last         = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= NUM_TIMERS)
    else $error("queued count beyond capacity");

  a_armed_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(armed_r) == int'(count_r))
    else $error("armed flags disagree with queued count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty list");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result written over an untaken result");

endmodule

// ----- rtl/sdtq_ctrl.sv -----
// Controller of the timer queue: sequences unlink, link, service pops and
// result writes. Depends on sdtq_pkg; drives sdtq_dp.
module sdtq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdtq_pkg::dp_status_t st,
  output sdtq_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_RESP,
    S_SRV_TEST,
    S_SRV_NEXT,
    S_SRV_NONE
  } state_t;

  state_t                            state_r, state_nxt;
  logic [sdtq_pkg::BURST_BITS-1:0]   burst_r, burst_nxt;
  logic                              more_due;

  assign in_ready = state_r == S_IDLE;
  assign more_due = st.head_due && (int'(burst_r) < sdtq_pkg::MAX_BURST);

  always_comb begin
    state_nxt     = state_r;
    burst_nxt     = burst_r;
    cmd           = '0;
    cmd.emit_kind = sdtq_pkg::EMIT_CMD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        burst_nxt = '0;
        if ((st.func inside {sdtq_pkg::FUNC_ARM, sdtq_pkg::FUNC_STOP}) && st.slot_ok) begin
          cmd.unlink = 1'b1;
          state_nxt  = (st.func == sdtq_pkg::FUNC_ARM) ? S_LINK : S_RESP;
        end else if (st.func == sdtq_pkg::FUNC_SERVICE) begin
          state_nxt = S_SRV_TEST;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SRV_TEST: begin
        // Only reached with nothing pending; no due head means an empty result
        if (more_due) begin
          cmd.pop   = 1'b1;
          burst_nxt = burst_r + 1'b1;
          state_nxt = S_SRV_NEXT;
        end else begin
          state_nxt = S_SRV_NONE;
        end
      end
      S_SRV_NEXT: begin
        // Report the popped slot once the next head is known
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sdtq_pkg::EMIT_FIRE;
          cmd.emit_last = !more_due;
          state_nxt     = more_due ? S_SRV_TEST : S_IDLE;
        end
      end
      S_SRV_NONE: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sdtq_pkg::EMIT_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      burst_r <= '0;
    end else begin
      state_r <= state_nxt;
      burst_r <= burst_nxt;
    end
  end

endmodule

// ----- rtl/sorted_deadline_timer_queue.sv -----
// Sorted deadline timer queue: one controller and one datapath.
// After a transfer the controller runs EXEC, then LINK for arm, then RESP to
// write the result; service runs EXEC, then SRV_TEST and SRV_NEXT per expiry.
// One item at a time: a new command is taken only after its last result write;
// each result write also waits for the output register.
// Reset (synchronous, rst_n low) empties the list and clears all armed flags.
module sorted_deadline_timer_queue #(
  parameter int NUM_TIMERS = sdtq_pkg::DEF_NUM_TIMERS,
  parameter int TIME_BITS  = sdtq_pkg::DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [30:0] in_delay,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_expired_slot,
  output logic        out_fired,
  output logic        out_slot_active,
  output logic        out_last
);

  sdtq_pkg::dp_cmd_t    cmd;
  sdtq_pkg::dp_status_t st;

  sdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sdtq_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_delay         (in_delay),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_expired_slot (out_expired_slot),
    .out_fired        (out_fired),
    .out_slot_active  (out_slot_active),
    .out_last         (out_last)
  );

endmodule

// ----- verif/sdtq_checker.sv -----
// Checker for the sorted deadline timer queue: watches both channels, keeps its
// own timer list and deadlines, and compares every result transfer in order.
// Depends on sdtq_pkg for function codes and sizes.
module sdtq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [30:0] in_delay,
  input  logic [31:0] in_now,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_expired_slot,
  input  logic        out_fired,
  input  logic        out_slot_active,
  input  logic        out_last,
  output int          fail_count,
  output int          results_pending,
  output int          items_seen,
  output int          expiries_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMERS = sdtq_pkg::DEF_NUM_TIMERS;

  typedef struct packed {
    logic [3:0] slot;
    logic       fired;
    logic       active;
    logic       last;
  } timer_result_t;

  logic [31:0]   deadline_of [TIMERS];
  logic          queued_flag [TIMERS];
  logic [3:0]    due_order [$];
  timer_result_t timer_results [$];

  // Wrap-aware: a is later than b when a - b is positive as a signed value
  function automatic bit is_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return (diff != 0) && !diff[31];
  endfunction

  function automatic void unlink_timer(logic [3:0] s);
    for (int i = 0; i < due_order.size(); i++) begin
      if (due_order[i] == s) begin
        due_order.delete(i);
        break;
      end
    end
    queued_flag[s] = 1'b0;
  endfunction

  // Insert behind every entry that is not later, so ties keep arrival order
  function automatic void link_timer(logic [3:0] s);
    int pos;
    pos = 0;
    if (due_order.size() >= TIMERS) return;
    while (pos < due_order.size() && !is_later(deadline_of[due_order[pos]], deadline_of[s]))
      pos++;
    due_order.insert(pos, s);
    queued_flag[s] = 1'b1;
  endfunction

  function automatic void predict_timer_results(logic [1:0] f, logic [3:0] s,
                                                logic [30:0] d, logic [31:0] now);
    int            fired_n;
    logic [3:0]    head;
    timer_result_t res;
    fired_n = 0;
    case (f)
      sdtq_pkg::FUNC_ARM, sdtq_pkg::FUNC_STOP: begin
        if (queued_flag[s]) unlink_timer(s);
        if (f == sdtq_pkg::FUNC_ARM) begin
          deadline_of[s] = now + {1'b0, d};
          link_timer(s);
        end
        res = '{slot: 4'd0, fired: 1'b0, active: queued_flag[s], last: 1'b1};
        timer_results.push_back(res);
      end
      sdtq_pkg::FUNC_SERVICE: begin
        while (due_order.size() > 0 && fired_n < sdtq_pkg::MAX_BURST &&
               !is_later(deadline_of[due_order[0]], now)) begin
          head = due_order.pop_front();
          queued_flag[head] = 1'b0;
          res = '{slot: head, fired: 1'b1, active: 1'b0, last: 1'b0};
          timer_results.push_back(res);
          fired_n++;
        end
        if (fired_n == 0) begin
          res = '{slot: 4'd0, fired: 1'b0, active: 1'b0, last: 1'b1};
          timer_results.push_back(res);
        end else begin
          timer_results[timer_results.size() - 1].last = 1'b1;
        end
      end
      default: begin
        res = '{slot: 4'd0, fired: 1'b0, active: 1'b0, last: 1'b1};
        timer_results.push_back(res);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        deadline_of[i] = '0;
        queued_flag[i] = 1'b0;
      end
      due_order.delete();
      timer_results.delete();
      fail_count    = 0;
      items_seen    = 0;
      expiries_seen = 0;
    end else begin
      // Results first: a result can never belong to an item taken at the same edge
      if (out_valid && out_ready) begin
        got = '{slot: out_expired_slot, fired: out_fired, active: out_slot_active,
                last: out_last};
        if (timer_results.size() == 0) begin
          $display("%0t: unexpected result slot=%0d fired=%0b active=%0b last=%0b",
                   $time, got.slot, got.fired, got.active, got.last);
          fail_count++;
        end else begin
          want = timer_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected slot=%0d fired=%0b active=%0b last=%0b",
                     $time, want.slot, want.fired, want.active, want.last);
            $display("%0t:          actual   slot=%0d fired=%0b active=%0b last=%0b",
                     $time, got.slot, got.fired, got.active, got.last);
            fail_count++;
          end
          if (got.fired === 1'b1) expiries_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predict_timer_results(in_func, in_slot, in_delay, in_now);
        items_seen++;
      end
    end
    results_pending = timer_results.size();
  end

endmodule

// ----- verif/sorted_deadline_timer_queue_tb.sv -----
// Testbench top for the sorted deadline timer queue: clock, reset, command
// stimulus with bursty sending and receiver stalls, watchdog and verdict.
// Depends on sdtq_pkg, sdtq_checker and the RTL top.
module sorted_deadline_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 125;

  // Function code with no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [3:0]  in_slot;
  logic [30:0] in_delay;
  logic [31:0] in_now;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_expired_slot;
  logic        out_fired;
  logic        out_slot_active;
  logic        out_last;

  int fail_count;
  int results_pending;
  int items_seen;
  int expiries_seen;
  int idle_cycles;
  int burst_left;
  int gap_max;
  logic long_hold_req;

  sorted_deadline_timer_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_delay         (in_delay),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_expired_slot (out_expired_slot),
    .out_fired        (out_fired),
    .out_slot_active  (out_slot_active),
    .out_last         (out_last)
  );

  sdtq_checker i_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall pattern changes every run; one long hold-off on request
  initial begin
    int mode;
    int run_len;
    out_ready = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(10, 80);
      repeat (run_len) begin
        @(negedge clk);
        if (long_hold_req) begin
          out_ready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          long_hold_req = 1'b0;
        end else begin
          case (mode)
            0:       out_ready = 1'b1;
            1:       out_ready = $urandom_range(0, 1);
            2:       out_ready = ($urandom_range(0, 3) == 0);
            default: out_ready = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Offer one command and hold it until transfer; then pace the next burst.
  // Called and returns at a falling edge.
  task automatic send_cmd(logic [1:0] f, logic [3:0] s, logic [30:0] d, logic [31:0] n);
    in_valid = 1'b1;
    in_func  = f;
    in_slot  = s;
    in_delay = d;
    in_now   = n;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gap_max > 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
  endtask

  // Hold the sender until every outstanding result has arrived
  task automatic drain_results();
    in_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    logic [31:0] tick;
    logic [30:0] dly;
    int          r;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = sdtq_pkg::FUNC_ARM;
    in_slot       = '0;
    in_delay      = '0;
    in_now        = '0;
    long_hold_req = 1'b0;
    burst_left    = 0;
    gap_max       = 4;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty service, unused code, stop of an idle slot
    send_cmd(sdtq_pkg::FUNC_SERVICE, 4'd0, 31'd0, 32'd0);
    send_cmd(FUNC_UNUSED, 4'hF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(sdtq_pkg::FUNC_STOP, 4'd5, 31'd0, 32'd0);
    // Fill every slot across the wrap point with tied deadlines, re-arm one
    for (int i = 0; i < sdtq_pkg::DEF_NUM_TIMERS; i++)
      send_cmd(sdtq_pkg::FUNC_ARM, 4'(i), 31'((i % 4) * 8), 32'hFFFF_FFF0);
    send_cmd(sdtq_pkg::FUNC_ARM, 4'd3, 31'd0, 32'hFFFF_FFF0);
    // Full expiry burst after the wrap
    send_cmd(sdtq_pkg::FUNC_SERVICE, 4'd0, 31'd0, 32'h0000_0020);
    send_cmd(sdtq_pkg::FUNC_STOP, 4'd7, 31'd0, 32'd0);
    // Largest delay fires exactly at its deadline, not one tick early
    send_cmd(sdtq_pkg::FUNC_ARM, 4'd0, 31'h7FFF_FFFF, 32'd0);
    send_cmd(sdtq_pkg::FUNC_SERVICE, 4'd0, 31'd0, 32'h7FFF_FFFE);
    send_cmd(sdtq_pkg::FUNC_SERVICE, 4'd0, 31'd0, 32'h7FFF_FFFF);
    send_cmd(sdtq_pkg::FUNC_ARM, 4'd1, 31'd0, 32'hFFFF_FFFF);
    send_cmd(sdtq_pkg::FUNC_SERVICE, 4'd0, 31'd0, 32'hFFFF_FFFF);
    drain_results();

    // Random phases: a moving clock with mostly well-formed arm/stop/service
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_max = 8;  long_hold_req = 1'b1; tick = $urandom(); end
        1: begin gap_max = 0;  tick = 32'hFFFF_F000; end
        2: begin gap_max = 3;  tick = $urandom(); end
        default: begin gap_max = 12; tick = $urandom(); end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r    = $urandom_range(0, 99);
        tick = tick + $urandom_range(0, 40);
        dly  = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 400));
        if (r < 40)
          send_cmd(sdtq_pkg::FUNC_ARM, 4'($urandom_range(0, 15)), dly, tick);
        else if (r < 52)
          send_cmd(sdtq_pkg::FUNC_STOP, 4'($urandom_range(0, 15)), 31'($urandom()), tick);
        else if (r < 90)
          send_cmd(sdtq_pkg::FUNC_SERVICE, 4'($urandom_range(0, 15)), 31'($urandom()), tick);
        else
          send_cmd(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   31'($urandom()), $urandom());
      end
      drain_results();
    end

    repeat (30) @(posedge clk);
    if (results_pending != 0)
      $display("%0t: %0d expected results never arrived", $time, results_pending);
    $display("Ran %0d timer commands with %0d expirations: full burst, tied deadlines,",
             items_seen, expiries_seen);
    $display("counter wrap, unused codes and a long output stall with a blocked input.");
    if (fail_count == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
